FILE: design/nctq_pkg.sv
// Shared types and constants for the nearest centroid query table.
// Used by the front, queue and back modules and by the top level.
// No dependencies.
`default_nettype none

package nctq_pkg;

  // Field widths
  localparam int CoordW  = 24;
  localparam int RadiusW = 23;
  localparam int HeightW = 20;
  localparam int DistW   = 8;
  localparam int TotalW  = 11;
  localparam int RsqW    = 2 * RadiusW;
  localparam int ActW    = 2;

  // Beat widths on the stream ports
  localparam int InDataW  = 128;
  localparam int OutDataW = 120;

  // Action codes carried in s_tuser
  localparam logic [ActW-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ActW-1:0] ACT_APPEND = 2'd1;
  localparam logic [ActW-1:0] ACT_QUERY  = 2'd2;

  // Interior radius after reset
  localparam logic [RadiusW-1:0] IR_RESET = 23'd200;

  // Command queue depth (power of two)
  localparam int QDepth = 2;

  // Decoded command kinds
  typedef enum logic [1:0] {
    K_CLEAR  = 2'd0,
    K_APPEND = 2'd1,
    K_QUERY  = 2'd2,
    K_NOP    = 2'd3
  } kind_t;

  // Command passed from the front to the back
  typedef struct packed {
    kind_t                      kind;
    logic signed [CoordW-1:0]   px;
    logic signed [CoordW-1:0]   py;
    logic signed [CoordW-1:0]   pz;
    logic        [RsqW-1:0]     rsq;
    logic        [HeightW-1:0]  height;
    logic        [DistW-1:0]    district;
  } cmd_t;

  // Result beat, entry_total in the lowest bits
  typedef struct packed {
    logic                       table_full;
    logic                       is_interior;
    logic        [HeightW-1:0]  found_height;
    logic signed [CoordW-1:0]   found_z;
    logic signed [CoordW-1:0]   found_y;
    logic signed [CoordW-1:0]   found_x;
    logic                       building_found;
    logic        [DistW-1:0]    nearest_district;
    logic                       district_valid;
    logic        [TotalW-1:0]   entry_total;
  } res_t;

endpackage

`default_nettype wire

FILE: design/nctq_front.sv
// Front end: input beat register, action decode and squared search radius.
// Depends on nctq_pkg; feeds nctq_queue.
`default_nettype none

module nctq_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [nctq_pkg::InDataW-1:0]  s_tdata,
  input  wire logic [nctq_pkg::ActW-1:0]     s_tuser,
  output logic                               push,
  output nctq_pkg::cmd_t                     push_cmd,
  input  wire logic                          q_ready
);
  import nctq_pkg::*;

  logic                       in_valid;
  kind_t                      in_kind;
  logic signed [CoordW-1:0]   in_x;
  logic signed [CoordW-1:0]   in_y;
  logic signed [CoordW-1:0]   in_z;
  logic        [RadiusW-1:0]  in_r;
  logic        [HeightW-1:0]  in_h;
  logic        [DistW-1:0]    in_d;
  kind_t                      kind_next;

  assign push     = in_valid && q_ready;
  assign s_tready = !in_valid || q_ready;

  // Action decode
  always_comb begin
    unique case (s_tuser)
      ACT_CLEAR:  kind_next = K_CLEAR;
      ACT_APPEND: kind_next = K_APPEND;
      ACT_QUERY:  kind_next = K_QUERY;
      default:    kind_next = K_NOP;
    endcase
  end

  // Input beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_kind <= kind_next;
      in_x    <= s_tdata[23:0];
      in_y    <= s_tdata[47:24];
      in_z    <= s_tdata[71:48];
      in_r    <= s_tdata[94:72];
      in_h    <= s_tdata[114:95];
      in_d    <= s_tdata[122:115];
    end
  end

  // Command toward the queue; radius squared here so the back only compares
  always_comb begin
    push_cmd.kind     = in_kind;
    push_cmd.px       = in_x;
    push_cmd.py       = in_y;
    push_cmd.pz       = in_z;
    push_cmd.rsq      = RsqW'(in_r) * RsqW'(in_r);
    push_cmd.height   = in_h;
    push_cmd.district = in_d;
  end

endmodule

`default_nettype wire

FILE: design/nctq_queue.sv
// Short command queue between the front and the back.
// Depends on nctq_pkg.
`default_nettype none

module nctq_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire nctq_pkg::cmd_t  push_cmd,
  output logic                 q_ready,
  input  wire logic            pop,
  output logic                 q_valid,
  output nctq_pkg::cmd_t       q_cmd
);
  import nctq_pkg::*;

  localparam int QAW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCW = $clog2(QDepth + 1);

  cmd_t             slots [QDepth];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QCW-1:0]   fill;

  assign q_valid = (fill != '0);
  assign q_ready = (fill != QCW'(QDepth));
  assign q_cmd   = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/nctq_back.sv
// Back end: entry memories, entry count, pipelined distance scan and
// result register. Depends on nctq_pkg; takes commands from nctq_queue.
`default_nettype none

module nctq_back #(
  parameter int MAX_ENTRIES = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  wire nctq_pkg::cmd_t                q_cmd,
  output logic                               pop,
  input  wire logic                          cfg_we,
  input  wire logic [nctq_pkg::RadiusW-1:0]  cfg_data,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [nctq_pkg::OutDataW-1:0]      m_tdata
);
  import nctq_pkg::*;

  localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int AbsW  = CoordW + 1;
  localparam int SqW   = 2 * AbsW - 1;
  localparam int SumW  = SqW + 1;
  localparam int PadW  = OutDataW - $bits(res_t);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  typedef struct packed {
    logic signed [CoordW-1:0]  x;
    logic signed [CoordW-1:0]  y;
    logic signed [CoordW-1:0]  z;
    logic        [HeightW-1:0] h;
    logic        [DistW-1:0]   d;
  } entry_t;

  // Entry memories
  logic signed [CoordW-1:0]  mem_x [MAX_ENTRIES];
  logic signed [CoordW-1:0]  mem_y [MAX_ENTRIES];
  logic signed [CoordW-1:0]  mem_z [MAX_ENTRIES];
  logic        [HeightW-1:0] mem_h [MAX_ENTRIES];
  logic        [DistW-1:0]   mem_d [MAX_ENTRIES];

  logic [1:0]               state;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic [CW-1:0]            ptr;
  logic                     issue;
  logic                     mem_we;
  logic                     start;

  logic [RadiusW-1:0]       ir;
  logic [RsqW-1:0]          isq;

  logic signed [CoordW-1:0] qx;
  logic signed [CoordW-1:0] qy;
  logic signed [CoordW-1:0] qz;
  logic [RsqW-1:0]          rsq;

  // Scan pipeline
  logic                     va, vb, vc, vd;
  entry_t                   ea, eb, ec, ed;
  logic [AbsW-1:0]          ax, ay, az;
  logic [SqW-1:0]           sx, sy, sz;
  logic [SumW-1:0]          dsum;
  logic signed [AbsW-1:0]   dx, dy, dz;

  // Running winners
  logic                     seen;
  logic                     found;
  logic                     interior;
  logic [SumW-1:0]          best_all;
  logic [SumW-1:0]          best_in;
  logic [DistW-1:0]         best_d;
  entry_t                   best_e;
  logic                     upd_all;
  logic                     upd_in;

  // Result register
  logic                     res_valid;
  res_t                     res;
  res_t                     res_next;
  logic                     res_load;
  logic                     res_free;

  assign res_free = !res_valid || m_tready;
  assign pop      = (state == ST_IDLE) && q_valid && res_free;
  assign issue    = (state == ST_SCAN) && (ptr != count);
  assign m_tvalid = res_valid;
  assign m_tdata  = {{PadW{1'b0}}, res};

  // Command execution and result assembly
  always_comb begin
    count_next = count;
    mem_we     = 1'b0;
    start      = 1'b0;
    res_load   = 1'b0;
    res_next   = '0;
    if (pop) begin
      unique case (q_cmd.kind)
        K_CLEAR: begin
          count_next = '0;
          res_load   = 1'b1;
        end
        K_APPEND: begin
          if (count == CW'(MAX_ENTRIES)) begin
            res_next.table_full = 1'b1;
          end else begin
            mem_we     = 1'b1;
            count_next = count + 1'b1;
          end
          res_load = 1'b1;
        end
        K_QUERY: begin
          if (count != '0) begin
            start = 1'b1;
          end else begin
            res_load = 1'b1;
          end
        end
        default: begin
          res_load = 1'b1;
        end
      endcase
      res_next.entry_total = TotalW'(count_next);
    end else if ((state == ST_DONE) && res_free) begin
      res_load                  = 1'b1;
      res_next.entry_total      = TotalW'(count);
      res_next.district_valid   = 1'b1;
      res_next.nearest_district = best_d;
      res_next.building_found   = found;
      res_next.found_x          = best_e.x;
      res_next.found_y          = best_e.y;
      res_next.found_z          = best_e.z;
      res_next.found_height     = best_e.h;
      res_next.is_interior      = interior;
    end
  end

  // Memory write on append, registered read during a scan
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[count[AW-1:0]] <= q_cmd.px;
      mem_y[count[AW-1:0]] <= q_cmd.py;
      mem_z[count[AW-1:0]] <= q_cmd.pz;
      mem_h[count[AW-1:0]] <= q_cmd.height;
      mem_d[count[AW-1:0]] <= q_cmd.district;
    end
    if (issue) begin
      ea.x <= mem_x[ptr[AW-1:0]];
      ea.y <= mem_y[ptr[AW-1:0]];
      ea.z <= mem_z[ptr[AW-1:0]];
      ea.h <= mem_h[ptr[AW-1:0]];
      ea.d <= mem_d[ptr[AW-1:0]];
    end
  end

  // Control: state, count, scan pointer, stage valids, config, result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      ptr       <= '0;
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      res_valid <= 1'b0;
      ir        <= IR_RESET;
      isq       <= RsqW'(IR_RESET) * RsqW'(IR_RESET);
    end else begin
      count <= count_next;
      va    <= issue;
      vb    <= va;
      vc    <= vb;
      vd    <= vc;
      if (cfg_we) begin
        ir <= cfg_data;
      end
      isq <= RsqW'(ir) * RsqW'(ir);
      if (res_load) begin
        res_valid <= 1'b1;
        res       <= res_next;
      end else if (m_tready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            ptr   <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            ptr <= ptr + 1'b1;
          end else if (!va && !vb && !vc && !vd) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Per-axis differences
  always_comb begin
    dx = {qx[CoordW-1], qx} - {ea.x[CoordW-1], ea.x};
    dy = {qy[CoordW-1], qy} - {ea.y[CoordW-1], ea.y};
    dz = {qz[CoordW-1], qz} - {ea.z[CoordW-1], ea.z};
  end

  // Stages: absolute difference, square, sum
  always_ff @(posedge clk) begin
    ax <= dx[AbsW-1] ? AbsW'(-dx) : AbsW'(dx);
    ay <= dy[AbsW-1] ? AbsW'(-dy) : AbsW'(dy);
    az <= dz[AbsW-1] ? AbsW'(-dz) : AbsW'(dz);
    eb <= ea;
    sx <= SqW'(ax) * SqW'(ax);
    sy <= SqW'(ay) * SqW'(ay);
    sz <= SqW'(az) * SqW'(az);
    ec <= eb;
    dsum <= SumW'(sx) + SumW'(sy) + SumW'(sz);
    ed   <= ec;
  end

  // Winner compares; strict less-than keeps the earlier entry on ties
  assign upd_all = !seen || (dsum < best_all);
  assign upd_in  = (dsum < SumW'(rsq)) && (!found || (dsum < best_in));

  // Query latch and running winners
  always_ff @(posedge clk) begin
    if (start) begin
      qx       <= q_cmd.px;
      qy       <= q_cmd.py;
      qz       <= q_cmd.pz;
      rsq      <= q_cmd.rsq;
      seen     <= 1'b0;
      found    <= 1'b0;
      interior <= 1'b0;
      best_e   <= '0;
    end else if (vd) begin
      seen <= 1'b1;
      if (upd_all) begin
        best_all <= dsum;
        best_d   <= ed.d;
      end
      if (upd_in) begin
        best_in <= dsum;
        best_e  <= ed;
        found   <= 1'b1;
      end
      if (dsum < SumW'(isq)) begin
        interior <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/nearest_centroid_query_table.sv
// Top level of the nearest centroid query table.
// Depends on nctq_pkg, nctq_front, nctq_queue and nctq_back.
//
// Usage:
//   s_* carries one command per beat: s_tuser holds the action (clear,
//   append, query) and s_tdata the position, radius and entry payload.
//   m_* returns exactly one result beat per command, in command order.
//   cfg_* writes the interior radius; write it only while the block is idle.
// Throughput:
//   Clear and append pass through the input register, the command queue and
//   the result register and sustain one command per cycle while m_tready is
//   high. A query streams through every entry, one memory read per cycle
//   through a 4-stage distance pipeline over the single read port of the
//   entry memories; no new command is taken until its result is loaded.
// Reset:
//   rst empties the command queue and result register, sets the entry count
//   to zero and the interior radius to 200. Memory contents are not cleared.
// Stall:
//   A result beat held by m_tready low blocks the back end; the front keeps
//   taking beats until the queue and its input register fill, then drops s_tready.
`default_nettype none

module nearest_centroid_query_table #(
  parameter int MAX_ENTRIES = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // s_tdata: pos_x[23:0], pos_y[47:24], pos_z[71:48], search_radius[94:72],
  //          entry_height[114:95], entry_district[122:115], zero[127:123]
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [nctq_pkg::InDataW-1:0]   s_tdata,
  // s_tuser: action[1:0]
  input  wire logic [nctq_pkg::ActW-1:0]      s_tuser,
  // m_tdata: entry_total[10:0], district_valid[11], nearest_district[19:12],
  //          building_found[20], found_x[44:21], found_y[68:45],
  //          found_z[92:69], found_height[112:93], is_interior[113],
  //          table_full[114], zero[119:115]
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [nctq_pkg::OutDataW-1:0]       m_tdata,
  // Interior radius write channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [nctq_pkg::RadiusW-1:0]   cfg_data
);
  import nctq_pkg::*;

  logic  push;
  cmd_t  push_cmd;
  logic  q_ready;
  logic  q_valid;
  cmd_t  q_cmd;
  logic  pop;

  assign cfg_ready = 1'b1;

  nctq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready)
  );

  nctq_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  nctq_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

FILE: tb/sv/nearest_centroid_query_table_tb.sv
// Self-checking testbench for nearest_centroid_query_table: directed and random
// clear/append/query beats against a scoreboard that predicts every result beat.
// Depends on nctq_pkg and the nearest_centroid_query_table top level.
module nearest_centroid_query_table_tb;
  import nctq_pkg::*;

  localparam int TableDepth = 1024;
  localparam int StallLimit = 6000;
  localparam int EndPause   = 40;
  localparam int PhaseItems = 140;

  // action code outside the three defined ones
  localparam logic [ActW-1:0] ACT_NONE = 2'd3;

  localparam logic signed [CoordW-1:0] CoordMax  = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin  = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic [RadiusW-1:0]       RadiusMax = {RadiusW{1'b1}};
  localparam logic [HeightW-1:0]       HeightMax = {HeightW{1'b1}};
  localparam logic [DistW-1:0]         DistMax   = {DistW{1'b1}};

  // Table mirror, nearest-entry prediction and result checking
  class centroid_scoreboard;
    logic signed [CoordW-1:0] ent_x [TableDepth];
    logic signed [CoordW-1:0] ent_y [TableDepth];
    logic signed [CoordW-1:0] ent_z [TableDepth];
    logic [HeightW-1:0]       ent_h [TableDepth];
    logic [DistW-1:0]         ent_d [TableDepth];
    int unsigned              count;
    logic [RadiusW-1:0]       interior_r;
    res_t                     pending_results[$];
    int                       mismatches;

    function new();
      count      = 0;
      interior_r = IR_RESET;
      mismatches = 0;
    endfunction

    function void set_interior(logic [RadiusW-1:0] r);
      interior_r = r;
    endfunction

    // predict the result beat of one accepted command beat
    function void note_command(logic [ActW-1:0] act, logic signed [CoordW-1:0] x,
                               logic signed [CoordW-1:0] y, logic signed [CoordW-1:0] z,
                               logic [RadiusW-1:0] r, logic [HeightW-1:0] h,
                               logic [DistW-1:0] d);
      res_t   e;
      longint dx, dy, dz, dsq, rsq, isq, best_all, best_in;
      int     idx_all, idx_in;
      bit     found, interior_hit;
      e = '0;
      case (act)
        ACT_CLEAR: begin
          count = 0;
        end
        ACT_APPEND: begin
          if (count >= TableDepth) begin
            e.table_full = 1'b1;
          end else begin
            ent_x[count] = x;
            ent_y[count] = y;
            ent_z[count] = z;
            ent_h[count] = h;
            ent_d[count] = d;
            count++;
          end
        end
        ACT_QUERY: begin
          if (count > 0) begin
            rsq          = longint'(r) * longint'(r);
            isq          = longint'(interior_r) * longint'(interior_r);
            best_all     = 0;
            best_in      = 0;
            idx_all      = 0;
            idx_in       = 0;
            found        = 0;
            interior_hit = 0;
            for (int k = 0; k < count; k++) begin
              dx  = longint'(x) - longint'(ent_x[k]);
              dy  = longint'(y) - longint'(ent_y[k]);
              dz  = longint'(z) - longint'(ent_z[k]);
              dsq = dx * dx + dy * dy + dz * dz;
              // strict compares keep the earlier entry on ties
              if (k == 0 || dsq < best_all) begin
                best_all = dsq;
                idx_all  = k;
              end
              if (dsq < rsq && (!found || dsq < best_in)) begin
                best_in = dsq;
                idx_in  = k;
                found   = 1;
              end
              if (dsq < isq) interior_hit = 1;
            end
            e.district_valid   = 1'b1;
            e.nearest_district = ent_d[idx_all];
            if (found) begin
              e.building_found = 1'b1;
              e.found_x        = ent_x[idx_in];
              e.found_y        = ent_y[idx_in];
              e.found_z        = ent_z[idx_in];
              e.found_height   = ent_h[idx_in];
            end
            e.is_interior = interior_hit;
          end
        end
        default: begin
        end
      endcase
      e.entry_total = count[TotalW-1:0];
      pending_results.push_back(e);
    endfunction

    function void check_field(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // compare one result beat against the oldest prediction
    function void check_beat(res_t got);
      res_t e;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result beat: expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      e = pending_results.pop_front();
      check_field("entry_total",      e.entry_total,      got.entry_total);
      check_field("district_valid",   e.district_valid,   got.district_valid);
      check_field("nearest_district", e.nearest_district, got.nearest_district);
      check_field("building_found",   e.building_found,   got.building_found);
      check_field("found_x",          e.found_x,          got.found_x);
      check_field("found_y",          e.found_y,          got.found_y);
      check_field("found_z",          e.found_z,          got.found_z);
      check_field("found_height",     e.found_height,     got.found_height);
      check_field("is_interior",      e.is_interior,      got.is_interior);
      check_field("table_full",       e.table_full,       got.table_full);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [InDataW-1:0]    s_tdata;
  logic [ActW-1:0]       s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OutDataW-1:0]   m_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [RadiusW-1:0]    cfg_data;

  centroid_scoreboard sb = new();
  bit tx_busy = 1'b1;
  bit rx_busy = 1'b1;
  int idle_cycles = 0;

  nearest_centroid_query_table dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Watchdog: too long without any beat on any channel
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random back-pressure, check every beat taken
  initial begin
    res_t got;
    int   stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) rx_busy = !rx_busy;
      stall = rx_busy ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got = m_tdata[$bits(res_t)-1:0];
      sb.check_beat(got);
      @(negedge clk);
    end
  end

  // Drive one command beat; called and returns at a falling edge
  task automatic send_command(input logic [ActW-1:0] act, input logic signed [CoordW-1:0] x,
                              input logic signed [CoordW-1:0] y,
                              input logic signed [CoordW-1:0] z,
                              input logic [RadiusW-1:0] r, input logic [HeightW-1:0] h,
                              input logic [DistW-1:0] d);
    int gap;
    if ($urandom_range(0, 19) == 0) tx_busy = !tx_busy;
    gap = tx_busy ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {5'b0, d, h, r, z, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_command(act, x, y, z, r, h, d);
    @(negedge clk);
  endtask

  // Hold off the sender until every predicted result has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_interior_radius(input logic [RadiusW-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_interior(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Coordinate near a cluster centre, sometimes anywhere in range
  function automatic logic signed [CoordW-1:0] near_coord(logic signed [CoordW-1:0] c);
    int span;
    int off;
    logic [31:0] raw;
    case ($urandom_range(0, 4))
      0: begin
        raw = $urandom;
        return raw[CoordW-1:0];
      end
      1: span = 40;
      2: span = 400;
      default: span = 3000;
    endcase
    off = int'($urandom_range(0, 2 * span)) - span;
    return c + off[CoordW-1:0];
  endfunction

  function automatic logic [RadiusW-1:0] pick_radius();
    case ($urandom_range(0, 3))
      0: return RadiusW'($urandom_range(0, 300));
      1: return RadiusW'($urandom_range(0, 6000));
      2: return RadiusW'($urandom_range(0, RadiusMax));
      default: return RadiusW'($urandom_range(0, 40));
    endcase
  endfunction

  // Mostly short tables: appends and queries around one cluster, rare clears
  task automatic random_phase(input int n_items);
    logic signed [CoordW-1:0] cx, cy, cz;
    logic [31:0]              raw;
    int                       sel;
    logic [ActW-1:0]          act;
    raw = $urandom; cx = raw[CoordW-1:0];
    raw = $urandom; cy = raw[CoordW-1:0];
    raw = $urandom; cz = raw[CoordW-1:0];
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 6)       act = ACT_CLEAR;
      else if (sel < 50) act = ACT_APPEND;
      else if (sel < 95) act = ACT_QUERY;
      else               act = ACT_NONE;
      send_command(act, near_coord(cx), near_coord(cy), near_coord(cz), pick_radius(),
                   HeightW'($urandom_range(0, HeightMax)),
                   DistW'($urandom_range(0, DistMax)));
    end
  endtask

  initial begin
    logic signed [CoordW-1:0] fx, fy, fz;
    logic [31:0]              raw;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = ACT_CLEAR;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty table, unused action, extremes
    send_command(ACT_QUERY, 0, 0, 0, RadiusMax, 0, 0);
    send_command(ACT_NONE, CoordMax, CoordMin, CoordMax, RadiusMax, HeightMax, DistMax);
    send_command(ACT_APPEND, CoordMax, CoordMin, 0, 0, HeightMax, DistMax);
    send_command(ACT_APPEND, CoordMin, CoordMax, CoordMin, RadiusMax, 0, 0);
    send_command(ACT_QUERY, CoordMax, CoordMin, 0, 0, 0, 0);
    send_command(ACT_QUERY, CoordMin, CoordMin, CoordMin, RadiusMax, HeightMax, DistMax);
    send_command(ACT_CLEAR, CoordMax, CoordMax, CoordMax, RadiusMax, HeightMax, DistMax);
    send_command(ACT_QUERY, CoordMin, CoordMax, 0, RadiusMax, 0, 0);
    // Two entries on the same centre: the earlier one must win ties
    send_command(ACT_APPEND, 0, 0, 0, 0, 111, 7);
    send_command(ACT_APPEND, 0, 0, 0, 0, 222, 9);
    send_command(ACT_APPEND, -24'sd3, -24'sd4, 0, 0, 333, 11);
    // Radius edge: distance exactly equal to the radius is outside
    send_command(ACT_QUERY, 100, 0, 0, 100, 0, 0);
    send_command(ACT_QUERY, 100, 0, 0, 101, 0, 0);
    // Interior edge at the reset radius
    send_command(ACT_QUERY, 200, 0, 0, RadiusMax, 0, 0);
    send_command(ACT_QUERY, 199, 0, 0, RadiusMax, 0, 0);
    send_command(ACT_QUERY, -24'sd3, -24'sd4, 0, 1, 0, 0);
    send_command(ACT_QUERY, CoordMax, CoordMax, CoordMax, RadiusMax, HeightMax, DistMax);
    send_command(ACT_NONE, 5, 5, 5, 5, 5, 5);

    write_interior_radius('0);
    random_phase(PhaseItems);

    // Fill the table to capacity, then overflow it
    write_interior_radius(RadiusMax);
    send_command(ACT_CLEAR, 0, 0, 0, 0, 0, 0);
    raw = $urandom; fx = raw[CoordW-1:0];
    raw = $urandom; fy = raw[CoordW-1:0];
    raw = $urandom; fz = raw[CoordW-1:0];
    for (int i = 0; i < TableDepth + 3; i++) begin
      send_command(ACT_APPEND, near_coord(fx), near_coord(fy), near_coord(fz), pick_radius(),
                   HeightW'($urandom_range(0, HeightMax)),
                   DistW'($urandom_range(0, DistMax)));
    end
    for (int i = 0; i < 3; i++) begin
      send_command(ACT_QUERY, near_coord(fx), near_coord(fy), near_coord(fz), pick_radius(),
                   HeightW'($urandom_range(0, HeightMax)),
                   DistW'($urandom_range(0, DistMax)));
    end
    send_command(ACT_NONE, fx, fy, fz, 0, 0, 0);
    send_command(ACT_CLEAR, fx, fy, fz, 0, 0, 0);

    write_interior_radius(3000);
    random_phase(PhaseItems);
    write_interior_radius(RadiusW'($urandom_range(1, RadiusMax)));
    random_phase(PhaseItems);
    write_interior_radius(IR_RESET);
    random_phase(PhaseItems);

    // Drain, then give stray beats time to show up
    wait_drained();
    repeat (EndPause) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/nctq_pkg.sv
design/nctq_front.sv
design/nctq_queue.sv
design/nctq_back.sv
design/nearest_centroid_query_table.sv
tb/sv/nearest_centroid_query_table_tb.sv
